/* rtl/bbpmu_pkg.sv */
// shared constants and types for the binary belief-propagation message update
package bbpmu_pkg;

  localparam int PROB_BITS_DEF = 16;
  localparam int ACC_W = 64;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [ACC_W-1:0] rem;
    logic [ACC_W-1:0] dvs;
  } div_lane_t;

endpackage

/* rtl/bbpmu_front.sv */
// front pipeline: saturation, divide-out scaling, normalization and weighted sums
module bbpmu_front #(
  parameter int PROB_BITS = bbpmu_pkg::PROB_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [PROB_BITS:0]    sender_belief,
  input  logic [PROB_BITS:0]    sender_prior,
  input  logic [PROB_BITS-1:0]  reverse_message,
  input  logic [PROB_BITS:0]    edge_weight,
  output bbpmu_pkg::div_lane_t  lane
);
  import bbpmu_pkg::*;

  localparam int ONE_W = PROB_BITS + 1;
  localparam int T_W   = 2 * PROB_BITS + 1;
  localparam int OBITS = 63 - 2 * PROB_BITS;
  localparam int O_W   = (OBITS < T_W) ? OBITS : T_W;
  localparam int LO_W  = (O_W + 1) / 2;
  localparam int HI_W  = O_W - LO_W;
  localparam int S_W   = $clog2(T_W + 1);
  localparam int PL_W  = T_W + LO_W;
  localparam int PH_W  = T_W + HI_W;
  localparam int SP_W  = ONE_W + O_W;
  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << PROB_BITS;

  function automatic logic [ONE_W-1:0] sat(input logic [ONE_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  logic v1, v2, v3, v4, v5;

  // stage 1
  logic [ONE_W-1:0] b_s, p_s, w_s, m_s;
  logic [T_W-1:0]   t0_next, t1_next, pw_next, nn_next;
  logic [T_W-1:0]   t0, t1, pw1, nn1;
  logic [ONE_W-1:0] p1_1, p0_1;

  // stage 2
  logic [T_W-1:0]   mx;
  logic [S_W-1:0]   s;
  logic [O_W-1:0]   o0, o1;
  logic [T_W-1:0]   pw2, nn2;
  logic [ONE_W-1:0] p1_2, p0_2;

  // stage 3
  logic [PL_W-1:0]  pw_lo, nn_lo;
  logic [PH_W-1:0]  pw_hi, nn_hi;
  logic [SP_W-1:0]  sp1, sp0;

  // stage 4
  logic [ACC_W-1:0] a_lo, a_hi, sp;

  // stage 5
  logic             zero5;
  logic [ACC_W-1:0] a1, sum;

  always_comb begin
    b_s = sat(sender_belief);
    p_s = sat(sender_prior);
    w_s = sat(edge_weight);
    m_s = {1'b0, reverse_message};
    t0_next = T_W'(ONE - b_s) * T_W'(m_s);
    t1_next = T_W'(b_s) * T_W'(ONE - m_s);
    pw_next = T_W'(p_s) * T_W'(w_s);
    nn_next = T_W'(ONE - p_s) * T_W'(ONE - w_s);
  end

  always_comb begin
    mx = (t0 > t1) ? t0 : t1;
    s = '0;
    for (int i = 0; i < T_W; i++) begin
      if (i >= OBITS && mx[i]) begin
        s = S_W'(i - OBITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    t0   <= t0_next;
    t1   <= t1_next;
    pw1  <= pw_next;
    nn1  <= nn_next;
    p1_1 <= p_s;
    p0_1 <= ONE - p_s;

    o0   <= O_W'(t0 >> s);
    o1   <= O_W'(t1 >> s);
    pw2  <= pw1;
    nn2  <= nn1;
    p1_2 <= p1_1;
    p0_2 <= p0_1;

    pw_lo <= PL_W'(pw2) * PL_W'(o1[LO_W-1:0]);
    pw_hi <= PH_W'(pw2) * PH_W'(o1[O_W-1:LO_W]);
    nn_lo <= PL_W'(nn2) * PL_W'(o0[LO_W-1:0]);
    nn_hi <= PH_W'(nn2) * PH_W'(o0[O_W-1:LO_W]);
    sp1   <= SP_W'(p1_2) * SP_W'(o1);
    sp0   <= SP_W'(p0_2) * SP_W'(o0);

    a_lo <= ACC_W'(pw_lo) + ACC_W'(nn_lo);
    a_hi <= ACC_W'(pw_hi) + ACC_W'(nn_hi);
    sp   <= ACC_W'(sp1) + ACC_W'(sp0);

    a1    <= a_lo + (a_hi << LO_W);
    sum   <= sp << PROB_BITS;
    zero5 <= (sp == '0);
  end

  assign lane = '{valid: v5, zero: zero5, rem: a1, dvs: sum};

endmodule

/* rtl/bbpmu_div_cell.sv */
// one restoring-division cell: produces one quotient bit and hands on to the next cell
module bbpmu_div_cell #(
  parameter int PROB_BITS = bbpmu_pkg::PROB_BITS_DEF,
  parameter bit SHIFT = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bbpmu_pkg::div_lane_t  lane_in,
  input  logic [PROB_BITS:0]    q_in,
  output bbpmu_pkg::div_lane_t  lane_out,
  output logic [PROB_BITS:0]    q_out
);
  import bbpmu_pkg::*;

  localparam int Q_W = PROB_BITS + 1;

  logic [ACC_W-1:0] r_sh, r_next;
  logic [Q_W-1:0]   q_sh, q_next;
  logic             valid, zero;
  logic [ACC_W-1:0] rem, dvs;
  logic [Q_W-1:0]   q;

  always_comb begin
    r_sh = SHIFT ? {lane_in.rem[ACC_W-2:0], 1'b0} : lane_in.rem;
    q_sh = SHIFT ? {q_in[Q_W-2:0], 1'b0} : q_in;
    if (r_sh >= lane_in.dvs) begin
      r_next = r_sh - lane_in.dvs;
      q_next = q_sh | Q_W'(1);
    end else begin
      r_next = r_sh;
      q_next = q_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= lane_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    zero <= lane_in.zero;
    rem  <= r_next;
    dvs  <= lane_in.dvs;
    q    <= q_next;
  end

  assign lane_out = '{valid: valid, zero: zero, rem: rem, dvs: dvs};
  assign q_out = q;

endmodule

/* rtl/binary_bp_message_update.sv */
// top level: binary belief-propagation message update, front pipeline and division chain
//
//   channel   handshake          fields
//   input     start, busy        sender_belief, sender_prior, reverse_message, edge_weight
//   result    done (strobe)      message_out
//
// one item per cycle; busy is high only during reset
// the path from transfer to result strobe runs through five front stages,
// PROB_BITS + 1 division cells in a row and one output register
// reset clears all valid bits; items in flight are dropped
// the result is shown for one cycle and cannot be stalled
module binary_bp_message_update #(
  parameter int PROB_BITS = bbpmu_pkg::PROB_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PROB_BITS:0]    sender_belief,
  input  logic [PROB_BITS:0]    sender_prior,
  input  logic [PROB_BITS-1:0]  reverse_message,
  input  logic [PROB_BITS:0]    edge_weight,
  output logic                  done,
  output logic [PROB_BITS-1:0]  message_out
);
  import bbpmu_pkg::*;

  localparam int Q_W = PROB_BITS + 1;
  localparam int CELLS = PROB_BITS + 1;
  localparam int LATENCY = PROB_BITS + 7;
  localparam logic [PROB_BITS-1:0] HALF = PROB_BITS'(1) << (PROB_BITS - 1);

  logic                  accept;
  div_lane_t             lane [CELLS+1];
  logic [Q_W-1:0]        qv   [CELLS+1];
  logic [PROB_BITS-1:0]  message_out_next;

  assign busy = rst;
  assign accept = start & ~busy;

  bbpmu_front #(
    .PROB_BITS(PROB_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .sender_belief   (sender_belief),
    .sender_prior    (sender_prior),
    .reverse_message (reverse_message),
    .edge_weight     (edge_weight),
    .lane            (lane[0])
  );

  assign qv[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    bbpmu_div_cell #(
      .PROB_BITS(PROB_BITS),
      .SHIFT    (k != 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (lane[k]),
      .q_in     (qv[k]),
      .lane_out (lane[k+1]),
      .q_out    (qv[k+1])
    );
  end

  always_comb begin
    if (lane[CELLS].zero) begin
      message_out_next = HALF;
    end else if (qv[CELLS][Q_W-1]) begin
      message_out_next = '1;
    end else if (qv[CELLS] == '0) begin
      message_out_next = PROB_BITS'(1);
    end else begin
      message_out_next = qv[CELLS][PROB_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane[CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    message_out <= message_out_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LATENCY) done)
    else $error("transfer without result after pipeline latency");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without matching transfer");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> message_out != '0)
    else $error("message out of clamp range");

endmodule

/* test/bbpmu_message_checker.sv */
// checker for the binary bp message update: predicts each message and compares the result stream
`timescale 1ns / 100ps

module bbpmu_message_checker #(
  parameter int PROB_BITS = bbpmu_pkg::PROB_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [PROB_BITS:0]   sender_belief,
  input  logic [PROB_BITS:0]   sender_prior,
  input  logic [PROB_BITS-1:0] reverse_message,
  input  logic [PROB_BITS:0]   edge_weight,
  input  logic                 done,
  input  logic [PROB_BITS-1:0] message_out,
  output int                   errors,
  output int                   pending
);

  localparam bit [63:0] ONE = 64'd1 << PROB_BITS;
  localparam int OBITS = 63 - 2 * PROB_BITS;

  logic [PROB_BITS-1:0] expected_msgs[$];

  function automatic bit [63:0] clip_to_one(input bit [63:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [PROB_BITS-1:0] predict_message(
    input logic [PROB_BITS:0]   b_in,
    input logic [PROB_BITS:0]   p_in,
    input logic [PROB_BITS-1:0] m_in,
    input logic [PROB_BITS:0]   w_in
  );
    bit [63:0]  b, p, m, w, t0, t1, peak, o0, o1, a0, a1, total, q;
    bit [127:0] numer;
    int         s;
    b = clip_to_one(64'(b_in));
    p = clip_to_one(64'(p_in));
    m = clip_to_one(64'(m_in));
    w = clip_to_one(64'(w_in));
    // divide the reverse message out, scaled by m*(1-m)
    t0 = (ONE - b) * m;
    t1 = b * (ONE - m);
    peak = (t0 > t1) ? t0 : t1;
    s = 0;
    while (s < 63 && (peak >> s) >= (64'd1 << OBITS))
      s++;
    o0 = t0 >> s;
    o1 = t1 >> s;
    a1 = (p * w) * o1 + ((ONE - p) * (ONE - w)) * o0;
    a0 = (p * (ONE - w)) * o1 + ((ONE - p) * w) * o0;
    total = a0 + a1;
    if (total == 0) begin
      q = ONE >> 1;
    end else begin
      numer = 128'(a1) << PROB_BITS;
      q = 64'(numer / 128'(total));
      if (q < 1)
        q = 1;
      if (q > ONE - 1)
        q = ONE - 1;
    end
    return q[PROB_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    logic [PROB_BITS-1:0] want;
    if (rst) begin
      errors = 0;
    end else begin
      if (start && !busy)
        expected_msgs = {expected_msgs, predict_message(sender_belief, sender_prior,
                                                        reverse_message, edge_weight)};
      if (done) begin
        if (expected_msgs.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result message_out=%0d", $time, message_out);
        end else begin
          want = expected_msgs.pop_front();
          if (message_out !== want) begin
            errors = errors + 1;
            $display("%0t: message_out mismatch expected=%0d actual=%0d",
                     $time, want, message_out);
          end
        end
      end
    end
    pending <= expected_msgs.size();
  end

endmodule

/* test/tb_binary_bp_message_update.sv */
// testbench top for the binary bp message update: stimulus, reset, clock and verdict
`timescale 1ns / 100ps

module tb_binary_bp_message_update;

  localparam int PB = bbpmu_pkg::PROB_BITS_DEF;
  localparam int ONE = 1 << PB;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT = 200000;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [PB:0]   sender_belief;
  logic [PB:0]   sender_prior;
  logic [PB-1:0] reverse_message;
  logic [PB:0]   edge_weight;
  logic          done;
  logic [PB-1:0] message_out;
  int            errors;
  int            pending;
  int            cycle_cnt;

  binary_bp_message_update #(.PROB_BITS(PB)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sender_belief(sender_belief), .sender_prior(sender_prior),
    .reverse_message(reverse_message), .edge_weight(edge_weight),
    .done(done), .message_out(message_out)
  );

  bbpmu_message_checker #(.PROB_BITS(PB)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sender_belief(sender_belief), .sender_prior(sender_prior),
    .reverse_message(reverse_message), .edge_weight(edge_weight),
    .done(done), .message_out(message_out),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // probability with weight on the edges and on values above one
  function automatic logic [PB:0] pick_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (PB+1)'(ONE);
      2: return (PB+1)'($urandom_range(ONE + 1, 2 * ONE - 1));
      3: return (PB+1)'($urandom_range(0, 15));
      4: return (PB+1)'(ONE - $urandom_range(0, 15));
      default: return (PB+1)'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic logic [PB-1:0] pick_reverse();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PB'(1);
      2: return PB'(ONE - 1);
      3: return PB'($urandom_range(0, 15));
      4: return PB'(ONE - 1 - $urandom_range(0, 15));
      default: return PB'($urandom_range(0, ONE - 1));
    endcase
  endfunction

  task automatic put_item(input int b, input int p, input int m, input int w);
    start <= 1'b1;
    sender_belief <= (PB+1)'(b);
    sender_prior <= (PB+1)'(p);
    reverse_message <= PB'(m);
    edge_weight <= (PB+1)'(w);
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      start <= 1'b0;
      sender_belief <= pick_prob();
      sender_prior <= pick_prob();
      reverse_message <= pick_reverse();
      edge_weight <= pick_prob();
      @(posedge clk);
    end
  endtask

  initial begin
    int sent;
    int burst;
    rst = 1'b1;
    start = 1'b0;
    sender_belief = '0;
    sender_prior = '0;
    reverse_message = '0;
    edge_weight = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: zero sums, clamps, saturation, reverse message at zero and one
    put_item(0, 0, 0, 0);
    put_item(ONE, ONE, ONE - 1, ONE);
    put_item(2 * ONE - 1, 2 * ONE - 1, 1, 2 * ONE - 1);
    put_item(0, ONE, ONE / 2, ONE);
    put_item(ONE, 0, ONE / 2, 0);
    put_item(ONE / 2, ONE, ONE / 2, 0);
    put_item(ONE / 2, ONE / 2, ONE / 2, ONE / 2);
    put_item(ONE, ONE / 2, 0, ONE);
    idle_cycles(3);
    put_item(12345, 40000, 0, 20000);
    put_item(0, 30000, ONE - 1, 50000);
    put_item(1, 1, 1, 1);
    put_item(ONE - 1, ONE - 1, ONE - 1, ONE - 1);
    put_item(2 * ONE - 1, 0, 0, ONE + 1);
    put_item(ONE + 1, 2 * ONE - 1, ONE - 1, 0);
    idle_cycles(1);
    put_item(20000, 0, 1, ONE);
    put_item(50000, ONE, ONE - 1, 1);
    put_item('h15555, 'h0aaaa, 'haaaa, 'h15555);
    put_item('h0aaaa, 'h15555, 'h5555, 'h0aaaa);

    // random bursts with random gaps, some stretches back to back
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        put_item(int'(pick_prob()), int'(pick_prob()), int'(pick_reverse()),
                 int'(pick_prob()));
        sent++;
      end
      if ($urandom_range(0, 2) != 0)
        idle_cycles($urandom_range(1, 6));
    end
    idle_cycles(1);

    while (pending != 0)
      @(posedge clk);
    repeat (PB + 12) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
